### rtl/ksd_pkg.sv
// Package: shared types and codes of the key sequence decoder.
package ksd_pkg;

   // Input function codes
   typedef enum logic [1:0] {
      FUNC_KEY   = 2'd0,
      FUNC_SEQ   = 2'd1,
      FUNC_ENT   = 2'd2,
      FUNC_ALARM = 2'd3
   } func_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_PRINT   = 2'd1,
      KIND_ERROR   = 2'd2,
      KIND_ALARM   = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_PRINT_LOW  = 1'b0,
      CSR_PRINT_HIGH = 1'b1
   } csr_index_type;

   localparam logic [7:0] PRINT_LOW_RESET  = 8'd32;
   localparam logic [7:0] PRINT_HIGH_RESET = 8'd126;

   // Control from the sequencer to every cell
   typedef struct packed {
      logic seq_we;   // write one sequence byte
      logic ent_we;   // write command and length
      logic step;     // commit the compare of the current key byte
      logic restart;  // reopen all candidates
   } ctrl_type;

   // Word fields broadcast to the cells
   typedef struct packed {
      logic [3:0]  entry_index;
      logic [2:0]  byte_position;
      logic [7:0]  table_byte;
      logic [15:0] entry_command;
      logic [3:0]  entry_length;
      logic [7:0]  key_byte;
   } op_type;

   // Priority scan handed from cell to cell
   typedef struct packed {
      logic        done;  // an earlier cell decided or the table ended
      logic        hit;   // an earlier cell still matches
      logic        full;  // that cell's sequence is complete
      logic [15:0] cmd;
   } scan_type;

endpackage

### rtl/ksd_req_if.sv
// Interface: request channel of the key sequence decoder.
interface ksd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  key_byte;
   logic [3:0]  entry_index;
   logic [2:0]  byte_position;
   logic [7:0]  table_byte;
   logic [15:0] entry_command;
   logic [3:0]  entry_length;

   modport source (output valid, func, key_byte, entry_index, byte_position, table_byte,
                   entry_command, entry_length, input ready);
   modport sink (input valid, func, key_byte, entry_index, byte_position, table_byte,
                 entry_command, entry_length, output ready);
endinterface

### rtl/ksd_rsp_if.sv
// Interface: response channel of the key sequence decoder.
interface ksd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] command_code;
   logic [7:0]  char_code;

   modport source (output valid, kind, command_code, char_code, input ready);
   modport sink (input valid, kind, command_code, char_code, output ready);
endinterface

### rtl/ksd_cell.sv
// Module: one table entry cell with its sequence, command and candidate bit.
module ksd_cell #(
   parameter int IDX = 0,
   parameter int MAX_SEQ_LEN = 8,
   localparam int POS_W = $clog2(MAX_SEQ_LEN),
   localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  ksd_pkg::ctrl_type ctrl,
   input  ksd_pkg::op_type   op,
   input  logic [POS_W-1:0]  pos,
   input  ksd_pkg::scan_type scan_in,
   output ksd_pkg::scan_type scan_out,
   output logic              cand
);

   logic [7:0]       bytes_ff [MAX_SEQ_LEN];
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [15:0]      cmd_ff;
   logic             cand_ff;
   logic             cand_in;
   logic             sel;
   logic             keep;

   assign sel  = (32'(op.entry_index) == IDX);
   assign keep = cand_ff && (len_ff > LEN_W'(pos)) && (bytes_ff[pos] == op.key_byte);
   assign cand = cand_ff;

   // saturate the length to the sequence capacity
   always_comb begin
      if (32'(op.entry_length) > MAX_SEQ_LEN) begin
         len_in = LEN_W'(MAX_SEQ_LEN);
      end else begin
         len_in = LEN_W'(op.entry_length);
      end
   end

   always_comb begin
      if (ctrl.restart) begin
         cand_in = 1'b1;
      end else if (ctrl.step) begin
         cand_in = keep;
      end else begin
         cand_in = cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.seq_we && sel && (32'(op.byte_position) < MAX_SEQ_LEN)) begin
         bytes_ff[POS_W'(op.byte_position)] <= op.table_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         cmd_ff  <= '0;
         cand_ff <= 1'b1;
      end else begin
         cand_ff <= cand_in;
         if (ctrl.ent_we && sel) begin
            len_ff <= len_in;
            cmd_ff <= op.entry_command;
         end
      end
   end

   // first deciding cell wins; a zero command ends the table
   always_comb begin
      scan_out = scan_in;
      if (!scan_in.done) begin
         if (cmd_ff == '0) begin
            scan_out.done = 1'b1;
         end else if (keep) begin
            scan_out.done = 1'b1;
            scan_out.hit  = 1'b1;
            scan_out.full = (len_ff == LEN_W'(pos) + LEN_W'(1));
            scan_out.cmd  = cmd_ff;
         end
      end
   end

endmodule

### rtl/key_sequence_decoder.sv
// Module: top level of the key sequence decoder, sequencer plus row of entry cells.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid / ready   func, key_byte, entry_index, byte_position,
//                                   table_byte, entry_command, entry_length
//   rsp_chan  out   valid / ready   kind, command_code, char_code
//   csr_*     in    csr_we          csr_index, csr_wdata
//
// One word is taken every cycle unless the output is stalled; all entry cells compare the key
// byte in parallel and a priority scan ripples through the row of cells in the same cycle.
// A result appears in the output register in the cycle after its word is taken.
// A new word is taken while the output register is empty or being drained.
// Reset (synchronous) clears lengths, commands and the gathered state; sequence
// bytes are not cleared and must be written before use.
module key_sequence_decoder #(
   parameter int NUM_ENTRIES = 16,
   parameter int MAX_SEQ_LEN = 8
) (
   input  logic       clock,
   input  logic       reset,
   ksd_req_if.sink    req_chan,
   ksd_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int POS_W = $clog2(MAX_SEQ_LEN);

   logic [7:0]        plow_ff;
   logic [7:0]        phigh_ff;
   logic [POS_W-1:0]  cnt_ff;
   logic [POS_W-1:0]  cnt_in;
   logic [7:0]        first_ff;
   logic [7:0]        first_in;
   logic              rsp_valid_ff;
   logic [1:0]        kind_ff;
   logic [1:0]        kind_in;
   logic [15:0]       cmd_ff;
   logic [15:0]       cmd_in;
   logic [7:0]        char_ff;
   logic [7:0]        char_in;
   logic              take;
   logic              emit;
   logic [7:0]        fb;
   ksd_pkg::ctrl_type ctrl;
   ksd_pkg::op_type   op;
   ksd_pkg::scan_type scan [NUM_ENTRIES+1];
   logic [NUM_ENTRIES-1:0] cand_vec;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.command_code = cmd_ff;
   assign rsp_chan.char_code    = char_ff;

   assign op.entry_index   = req_chan.entry_index;
   assign op.byte_position = req_chan.byte_position;
   assign op.table_byte    = req_chan.table_byte;
   assign op.entry_command = req_chan.entry_command;
   assign op.entry_length  = req_chan.entry_length;
   assign op.key_byte      = req_chan.key_byte;

   assign scan[0] = '0;

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      ksd_cell #(
         .IDX(i),
         .MAX_SEQ_LEN(MAX_SEQ_LEN)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .op(op),
         .pos(cnt_ff),
         .scan_in(scan[i]),
         .scan_out(scan[i+1]),
         .cand(cand_vec[i])
      );
   end

   assign fb = (cnt_ff == '0) ? req_chan.key_byte : first_ff;

   always_comb begin
      emit         = 1'b0;
      kind_in      = ksd_pkg::KIND_ERROR;
      cmd_in       = '0;
      char_in      = '0;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      ctrl.seq_we  = 1'b0;
      ctrl.ent_we  = 1'b0;
      ctrl.step    = 1'b0;
      case (ksd_pkg::func_type'(req_chan.func))
         ksd_pkg::FUNC_KEY: begin
            if (req_chan.key_byte == '0) begin
               emit = 1'b1;
            end else begin
               ctrl.step = take;
               if (scan[NUM_ENTRIES].hit) begin
                  if (scan[NUM_ENTRIES].full) begin
                     emit    = 1'b1;
                     kind_in = ksd_pkg::KIND_COMMAND;
                     cmd_in  = scan[NUM_ENTRIES].cmd;
                  end else begin
                     // partial match: hold candidates, wait for more
                     cnt_in   = cnt_ff + POS_W'(1);
                     first_in = fb;
                  end
               end else begin
                  emit    = 1'b1;
                  char_in = fb;
                  if ((cnt_ff == '0) && (fb >= plow_ff) && (fb <= phigh_ff)) begin
                     kind_in = ksd_pkg::KIND_PRINT;
                  end
               end
            end
         end
         ksd_pkg::FUNC_SEQ: begin
            ctrl.seq_we = take;
         end
         ksd_pkg::FUNC_ENT: begin
            ctrl.ent_we = take;
         end
         ksd_pkg::FUNC_ALARM: begin
            if (cnt_ff == '0) begin
               emit    = 1'b1;
               kind_in = ksd_pkg::KIND_ALARM;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      ctrl.restart = take && emit;
      if (emit) begin
         cnt_in   = '0;
         first_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plow_ff  <= ksd_pkg::PRINT_LOW_RESET;
         phigh_ff <= ksd_pkg::PRINT_HIGH_RESET;
      end else if (csr_we) begin
         case (ksd_pkg::csr_index_type'(csr_index))
            ksd_pkg::CSR_PRINT_LOW:  plow_ff  <= csr_wdata;
            ksd_pkg::CSR_PRINT_HIGH: phigh_ff <= csr_wdata;
            default:                 plow_ff  <= plow_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            cnt_ff   <= cnt_in;
            first_ff <= first_in;
         end
         if (take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (take && emit) begin
         kind_ff <= kind_in;
         cmd_ff  <= cmd_in;
         char_ff <= char_in;
      end
   end

`ifndef SYNTHESIS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> (cnt_ff == '0) && (cand_vec == '1))
      else $error("gathered state not cleared after a result");

   a_gather_has_cand: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (cand_vec != '0))
      else $error("gathering with no candidate left");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(take && rsp_valid_ff && !rsp_chan.ready))
      else $error("word taken while result is stalled");

   a_cmd_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff != ksd_pkg::KIND_COMMAND)) |-> (cmd_ff == '0))
      else $error("command code on a non-command result");

   a_char_zero_on_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((kind_ff == ksd_pkg::KIND_COMMAND) ||
                        (kind_ff == ksd_pkg::KIND_ALARM))) |-> (char_ff == '0))
      else $error("character code on a command or alarm result");
`endif

endmodule

### verif/tb_key_sequence_decoder.sv
`timescale 1ns / 1ps
// Testbench: self-checking random regression of the key sequence decoder.
module tb_key_sequence_decoder;

   localparam int ENTRIES     = 16;
   localparam int SEQ_LEN     = 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      ksd_pkg::func_type func;
      logic [7:0]        key_byte;
      logic [3:0]        entry_index;
      logic [2:0]        byte_position;
      logic [7:0]        table_byte;
      logic [15:0]       entry_command;
      logic [3:0]        entry_length;
   } word_type;

   typedef struct {
      ksd_pkg::kind_type kind;
      logic [15:0]       command_code;
      logic [7:0]        char_code;
   } outcome_type;

   class decode_scoreboard_type;
      logic [7:0]         seq_bytes [ENTRIES][SEQ_LEN];
      logic [3:0]         seq_lens [ENTRIES];
      logic [15:0]        commands [ENTRIES];
      logic [ENTRIES-1:0] live;
      int unsigned        gathered;
      logic [7:0]         lead_byte;
      logic [7:0]         print_low;
      logic [7:0]         print_high;
      outcome_type        expected_outcomes[$];
      int                 mismatches;

      function new();
         foreach (seq_bytes[i, j]) seq_bytes[i][j] = 8'h00;
         foreach (seq_lens[i]) begin
            seq_lens[i] = 4'd0;
            commands[i] = 16'h0000;
         end
         print_low  = ksd_pkg::PRINT_LOW_RESET;
         print_high = ksd_pkg::PRINT_HIGH_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         live      = '1;
         gathered  = 0;
         lead_byte = 8'h00;
      endfunction

      function void push(ksd_pkg::kind_type k, logic [15:0] cmd, logic [7:0] ch);
         outcome_type o;
         o.kind         = k;
         o.command_code = cmd;
         o.char_code    = ch;
         expected_outcomes.push_back(o);
         restart();
      endfunction

      function void decode_key(logic [7:0] b);
         int unsigned pos;
         bit decided;
         if (b == 8'h00) begin
            push(ksd_pkg::KIND_ERROR, 16'h0000, 8'h00);
            return;
         end
         pos = gathered;
         if (pos == 0) lead_byte = b;
         // drop every entry that fails at this position
         for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && !(pos < SEQ_LEN && seq_lens[i] > pos && seq_bytes[i][pos] == b))
               live[i] = 1'b0;
         end
         gathered = pos + 1;
         decided = 1'b0;
         for (int i = 0; i < ENTRIES && !decided; i++) begin
            if (commands[i] == 16'h0000) break;
            if (live[i]) begin
               decided = 1'b1;
               if (seq_lens[i] == gathered)
                  push(ksd_pkg::KIND_COMMAND, commands[i], 8'h00);
            end
         end
         if (!decided) begin
            if (gathered == 1 && lead_byte >= print_low && lead_byte <= print_high)
               push(ksd_pkg::KIND_PRINT, 16'h0000, lead_byte);
            else
               push(ksd_pkg::KIND_ERROR, 16'h0000, lead_byte);
         end
      endfunction

      function void note_word(word_type w);
         case (w.func)
            ksd_pkg::FUNC_KEY: decode_key(w.key_byte);
            ksd_pkg::FUNC_SEQ: seq_bytes[w.entry_index][w.byte_position] = w.table_byte;
            ksd_pkg::FUNC_ENT: begin
               commands[w.entry_index] = w.entry_command;
               seq_lens[w.entry_index] = (w.entry_length > SEQ_LEN) ? 4'(SEQ_LEN) : w.entry_length;
            end
            default: if (gathered == 0) push(ksd_pkg::KIND_ALARM, 16'h0000, 8'h00);
         endcase
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_outcome(outcome_type got);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            report($sformatf("unexpected result kind %0d cmd %h char %h",
                             got.kind, got.command_code, got.char_code));
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.command_code !== want.command_code)
            report($sformatf("command_code %h, expected %h", got.command_code, want.command_code));
         if (got.char_code !== want.char_code)
            report($sformatf("char_code %h, expected %h", got.char_code, want.char_code));
      endtask

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void set_register(ksd_pkg::csr_index_type idx, logic [7:0] value);
         if (idx == ksd_pkg::CSR_PRINT_LOW) print_low = value;
         else print_high = value;
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   ksd_pkg::csr_index_type csr_index;
   logic [7:0]             csr_wdata;

   ksd_req_if req_chan();
   ksd_rsp_if rsp_chan();

   key_sequence_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   decode_scoreboard_type board = new();

   // stimulus-side picture of the table, used only to shape key streams and table writes
   logic [7:0]  shadow_seq [ENTRIES][SEQ_LEN];
   bit          written [ENTRIES][SEQ_LEN];
   int          shadow_len [ENTRIES];
   logic [15:0] shadow_cmd [ENTRIES];
   bit          gaps_on;
   bit          calm;
   bit          hold_request;
   int          words_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      outcome_type got;
      word_type    seen;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind         = ksd_pkg::kind_type'(rsp_chan.kind);
            got.command_code = rsp_chan.command_code;
            got.char_code    = rsp_chan.char_code;
            board.check_outcome(got);
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.func          = ksd_pkg::func_type'(req_chan.func);
            seen.key_byte      = req_chan.key_byte;
            seen.entry_index   = req_chan.entry_index;
            seen.byte_position = req_chan.byte_position;
            seen.table_byte    = req_chan.table_byte;
            seen.entry_command = req_chan.entry_command;
            seen.entry_length  = req_chan.entry_length;
            board.note_word(seen);
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic word_type noise_word(ksd_pkg::func_type f);
      word_type w;
      w.func          = f;
      w.key_byte      = 8'($urandom);
      w.entry_index   = 4'($urandom);
      w.byte_position = 3'($urandom);
      w.table_byte    = 8'($urandom);
      w.entry_command = 16'($urandom);
      w.entry_length  = 4'($urandom);
      return w;
   endfunction

   // bytes drawn mostly from escape-like material so that prefixes overlap
   function automatic logic [7:0] seq_byte();
      case ($urandom_range(0, 15))
         0, 1, 2: return 8'h1B;
         3, 4:    return 8'h5B;
         5:       return 8'h4F;
         6, 7:    return 8'($urandom_range(8'h30, 8'h39));
         8, 9:    return 8'($urandom_range(8'h41, 8'h44));
         10:      return 8'h7E;
         11:      return 8'h00;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic send_word(input word_type w);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.func          <= w.func;
      req_chan.key_byte      <= w.key_byte;
      req_chan.entry_index   <= w.entry_index;
      req_chan.byte_position <= w.byte_position;
      req_chan.table_byte    <= w.table_byte;
      req_chan.entry_command <= w.entry_command;
      req_chan.entry_length  <= w.entry_length;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic send_key(input logic [7:0] b);
      word_type w;
      w = noise_word(ksd_pkg::FUNC_KEY);
      w.key_byte = b;
      send_word(w);
   endtask

   task automatic send_alarm();
      send_word(noise_word(ksd_pkg::FUNC_ALARM));
   endtask

   task automatic put_seq(input int e, input int p, input logic [7:0] b);
      word_type w;
      w = noise_word(ksd_pkg::FUNC_SEQ);
      w.entry_index   = 4'(e);
      w.byte_position = 3'(p);
      w.table_byte    = b;
      shadow_seq[e][p] = b;
      written[e][p]    = 1'b1;
      send_word(w);
   endtask

   // fill any sequence byte the new length exposes before the length lands
   task automatic put_entry(input int e, input logic [15:0] cmd, input int len, input bit fresh);
      word_type w;
      int used;
      used = (len > SEQ_LEN) ? SEQ_LEN : len;
      for (int p = 0; p < used; p++) begin
         if (fresh || !written[e][p]) put_seq(e, p, seq_byte());
      end
      w = noise_word(ksd_pkg::FUNC_ENT);
      w.entry_index   = 4'(e);
      w.entry_command = cmd;
      w.entry_length  = 4'(len);
      shadow_len[e] = used;
      shadow_cmd[e] = cmd;
      send_word(w);
   endtask

   task automatic load_table();
      int live_n;
      int len;
      logic [15:0] cmd;
      live_n = $urandom_range(1, ENTRIES);
      for (int e = 0; e < ENTRIES; e++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(SEQ_LEN + 1, 15)
                                           : $urandom_range(0, SEQ_LEN);
         cmd = (e == live_n) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
         put_entry(e, cmd, len, 1'b1);
      end
   endtask

   // follow a live entry for a random prefix, sometimes break off
   task automatic play_sequence();
      int last;
      int e;
      int k;
      last = 0;
      while (last < ENTRIES && shadow_cmd[last] != 16'h0000) last++;
      e = (last == 0) ? $urandom_range(0, ENTRIES - 1) : $urandom_range(0, last - 1);
      if (shadow_len[e] == 0) begin
         send_key(seq_byte());
         return;
      end
      k = $urandom_range(1, shadow_len[e]);
      for (int p = 0; p < k; p++) send_key(shadow_seq[e][p]);
      if ($urandom_range(0, 3) == 0) send_key(seq_byte());
   endtask

   task automatic run_traffic(input int count);
      int stop;
      int r;
      stop = words_sent + count;
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 50) play_sequence();
         else if (r < 65) send_key(8'($urandom_range(1, 255)));
         else if (r < 72) send_alarm();
         else if (r < 76) send_key(8'h00);
         else if (r < 90) put_seq($urandom_range(0, ENTRIES - 1), $urandom_range(0, SEQ_LEN - 1),
                                  seq_byte());
         else put_entry($urandom_range(0, ENTRIES - 1),
                        ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom),
                        $urandom_range(0, 15), 1'b0);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      // table words and partial keys leave nothing behind to wait for
      repeat (3) @(posedge clock);
   endtask

   task automatic set_printable(input logic [7:0] lo, input logic [7:0] hi);
      drain();
      csr_we    <= 1'b1;
      csr_index <= ksd_pkg::CSR_PRINT_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      board.set_register(ksd_pkg::CSR_PRINT_LOW, lo);
      csr_index <= ksd_pkg::CSR_PRINT_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      board.set_register(ksd_pkg::CSR_PRINT_HIGH, hi);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= ksd_pkg::CSR_PRINT_LOW;
      csr_wdata              <= 8'h00;
      req_chan.valid         <= 1'b0;
      req_chan.func          <= ksd_pkg::FUNC_KEY;
      req_chan.key_byte      <= 8'h00;
      req_chan.entry_index   <= 4'd0;
      req_chan.byte_position <= 3'd0;
      req_chan.table_byte    <= 8'h00;
      req_chan.entry_command <= 16'h0000;
      req_chan.entry_length  <= 4'd0;
      gaps_on      = 1'b0;
      calm         = 1'b0;
      hold_request = 1'b0;
      words_sent   = 0;
      foreach (written[i, j]) begin
         written[i][j]    = 1'b0;
         shadow_seq[i][j] = 8'h00;
      end
      foreach (shadow_len[i]) begin
         shadow_len[i] = 0;
         shadow_cmd[i] = 16'h0000;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // alarm when idle, zero key, printable range edges on an empty table
      send_alarm();
      send_key(8'h00);
      send_key(8'd31);
      send_key(8'd32);
      send_key(8'd126);
      send_key(8'd127);
      send_key(8'hFF);
      // one two-byte command with an all-ones code
      put_seq(0, 0, 8'h1B);
      put_seq(0, 1, 8'h5B);
      put_entry(0, 16'hFFFF, 2, 1'b0);
      // alarm in the middle of a sequence is dropped
      send_key(8'h1B);
      send_alarm();
      send_key(8'h5B);
      // divergence after one byte, then zero key while gathering
      send_key(8'h1B);
      send_key(8'h78);
      send_key(8'h1B);
      send_key(8'h00);
      // rewrite the table under a partial match
      send_key(8'h1B);
      put_seq(0, 1, 8'h4F);
      send_key(8'h4F);
      // entry with no sequence is skipped
      put_entry(0, 16'h1234, 0, 1'b0);
      send_key(8'h1B);

      gaps_on = 1'b1;
      set_printable(8'd0, 8'd255);
      load_table();
      run_traffic(220);

      // empty printable range
      set_printable(8'd255, 8'd0);
      load_table();
      run_traffic(200);

      set_printable(8'd0, 8'd0);
      load_table();
      hold_request = 1'b1;
      run_traffic(200);

      set_printable(8'd255, 8'd255);
      load_table();
      run_traffic(120);
      drain();
      run_traffic(100);

      set_printable(8'($urandom), 8'($urandom));
      load_table();
      run_traffic(220);

      set_printable(8'($urandom_range(0, 64)), 8'($urandom_range(64, 255)));
      load_table();
      run_traffic(220);

      // last stretch runs flat out on both sides
      set_printable(ksd_pkg::PRINT_LOW_RESET, ksd_pkg::PRINT_HIGH_RESET);
      gaps_on = 1'b0;
      calm    = 1'b1;
      load_table();
      run_traffic(200);

      drain();
      repeat (5) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/ksd_pkg.sv
rtl/ksd_req_if.sv
rtl/ksd_rsp_if.sv
rtl/ksd_cell.sv
rtl/key_sequence_decoder.sv
verif/tb_key_sequence_decoder.sv
